### hdl/assert_macros.svh
// Assertion macros used by the checker file mdfm_checker.sv.
// No dependencies; clocked on clk, reset rst_n (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is asserted.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check that stays live through reset.
`define CHK_ASSERT_NR(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mdfm_pkg.sv
// Motor drive fault monitor: shared constants, types and helper functions.
// No dependencies; used by every other file of the block except assert_macros.svh.
package mdfm_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int ACCUM_BITS   = 40;
  localparam int CURRENT_BITS = 16;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int MAG_W    = 15;
  localparam int VDC_W    = 16;
  localparam int TEMP_W   = 13;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int LIMIT_W  = 40;
  localparam int CMP_W    = 32;
  localparam int FLAGS_W  = 9;

  // input tdata layout, lowest field first
  localparam int IA_LSB     = 0;
  localparam int IB_LSB     = IA_LSB + CURRENT_BITS;
  localparam int IC_LSB     = IB_LSB + CURRENT_BITS;
  localparam int MAG_LSB    = IC_LSB + CURRENT_BITS;
  localparam int VDC_LSB    = MAG_LSB + MAG_W;
  localparam int TEMP_LSB   = VDC_LSB + VDC_W;
  localparam int HW_LSB     = TEMP_LSB + TEMP_W;
  localparam int IN_FIELD_W = HW_LSB + 1;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_EVT_BIT = FLAGS_W;
  localparam int OUT_DATA_W  = ((FLAGS_W + 1 + 7) / 8) * 8;

  // APB
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;

  // commands
  localparam logic [CMD_W-1:0] CMD_FAST  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SLOW  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // fault flag bit positions
  localparam int FB_OC_A   = 0;
  localparam int FB_OC_B   = 1;
  localparam int FB_OC_C   = 2;
  localparam int FB_OC_MAG = 3;
  localparam int FB_OV     = 4;
  localparam int FB_UV     = 5;
  localparam int FB_HW     = 6;
  localparam int FB_OL     = 7;
  localparam int FB_OT     = 8;

  // register indexes
  localparam logic [2:0] REG_OC_TRIP   = 3'd0;
  localparam logic [2:0] REG_OV_TRIP   = 3'd1;
  localparam logic [2:0] REG_UV_TRIP   = 3'd2;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd3;
  localparam logic [2:0] REG_OT_TRIP   = 3'd4;
  localparam logic [2:0] REG_OL_CONT   = 3'd5;
  localparam logic [2:0] REG_SUM_TRIP  = 3'd6;

  // register reset values
  localparam logic [MAG_W-1:0]   OC_TRIP_RST  = 15'd32767;
  localparam logic [VDC_W-1:0]   OV_TRIP_RST  = 16'd65535;
  localparam logic [VDC_W-1:0]   UV_TRIP_RST  = 16'd0;
  localparam logic [15:0]        DEBOUNCE_RST = 16'd20;
  localparam logic [TEMP_W-1:0]  OT_TRIP_RST  = 13'd2500;
  localparam logic [MAG_W-1:0]   OL_CONT_RST  = 15'd32767;
  localparam logic [SQ_W-1:0]    OL_SQ_RST    = SQ_W'(32'd32767 * 32'd32767);
  localparam logic [LIMIT_W-1:0] SUM_TRIP_RST = '1;

  typedef struct packed {
    logic [MAG_W-1:0]          oc_trip;
    logic [VDC_W-1:0]          ov_trip;
    logic [VDC_W-1:0]          uv_trip;
    logic [15:0]               debounce_count;
    logic signed [TEMP_W-1:0]  ot_trip;
    logic [SQ_W-1:0]           ol_sq;      // ol_cont_current squared
    logic [LIMIT_W-1:0]        sum_trip;   // overload sum limit
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]               cmd;
    logic [CURRENT_BITS-1:0]        ia;
    logic [CURRENT_BITS-1:0]        ib;
    logic [CURRENT_BITS-1:0]        ic;
    logic [MAG_W-1:0]               is_mag;
    logic [SQ_W-1:0]                is_sq;
    logic [VDC_W-1:0]               vdc;
    logic signed [TEMP_W-1:0]       temperature;
    logic                           hw_trip;
  } item_t;

  typedef struct packed {
    logic [FLAGS_W-1:0]      fault_latch;
    logic [COUNTER_BITS-1:0] ov_cnt;
    logic [COUNTER_BITS-1:0] uv_cnt;
    logic [COUNTER_BITS-1:0] ot_cnt;
    logic [ACCUM_BITS-1:0]   ol_sum;
  } state_t;

  // magnitude of a two's complement phase current
  function automatic logic [CURRENT_BITS-1:0] cur_mag(input logic [CURRENT_BITS-1:0] s);
    cur_mag = s[CURRENT_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  // up/down debounce counter, saturating at both ends
  function automatic logic [COUNTER_BITS-1:0] debounce(input logic [COUNTER_BITS-1:0] cnt,
                                                       input logic cond);
    if (cond) begin
      debounce = (&cnt) ? cnt : cnt + 1'b1;
    end else begin
      debounce = (cnt != '0) ? cnt - 1'b1 : '0;
    end
  endfunction

endpackage

### hdl/motor_drive_fault_monitor_top.sv
// Motor drive fault monitor, top level: stream channels, item register and result register.
// Depends on mdfm_pkg, mdfm_cfg and mdfm_eval.
//
// Usage:
//   in_*  : one item per handshake; in_tuser carries the command (fast check, slow
//           check, clear), in_tdata the measurements. Every item returns one result.
//   out_* : latched fault flags after the item, plus the magnitude overcurrent event.
//   APB   : seven 64-bit-wide registers at byte address 8*i; write only while idle.
// Path: an accepted item is written into the item register, then into the result
//   register, which drives out_tvalid and out_tdata.
// Throughput: one item per cycle while out_tready is high. The item register feeds
//   one pass of compare, debounce and 40-bit I^2t add/compare logic that writes the
//   state and the result register at the same edge, so the next item sees updated state.
//   The is_mag square is formed on the way into the item register; the square of
//   the continuous current is formed when its configuration register is written.
// Stall: while out_tready is low the result holds; one more item can still be
//   taken into the item register, then in_tready drops.
// Reset (rst_n low, synchronous): latches, debounce counters and the overload
//   sum clear, registers return to their defaults, both stages empty.
module motor_drive_fault_monitor_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [15:0] ia, [31:16] ib, [47:32] ic, [62:48] is_mag, [78:63] vdc,
  // [91:79] temperature, [92] hw_trip, rest zero
  input  logic [mdfm_pkg::IN_DATA_W-1:0]    in_tdata,
  // [1:0] cmd
  input  logic [mdfm_pkg::CMD_W-1:0]        in_tuser,
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [8:0] fault_flags, [9] oc_mag_event, rest zero
  output logic [mdfm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mdfm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [mdfm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [mdfm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int CurW = mdfm_pkg::CURRENT_BITS;
  localparam int SqW  = mdfm_pkg::SQ_W;
  localparam int OutW = mdfm_pkg::OUT_DATA_W;

  mdfm_pkg::cfg_t   cfg;
  mdfm_pkg::item_t  item_r;
  mdfm_pkg::item_t  item_nxt;
  mdfm_pkg::state_t st_r;
  mdfm_pkg::state_t st_nxt;
  logic             oc_evt;
  logic             item_vld_r;
  logic             out_vld_r;
  logic [OutW-1:0]  out_data_r;
  logic             in_acc;
  logic             item_adv;
  logic [mdfm_pkg::MAG_W-1:0] in_mag;

  mdfm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mdfm_eval u_eval (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg),
    .st_nxt (st_nxt),
    .oc_evt (oc_evt)
  );

  // item stage moves when the result register is free or being drained
  assign item_adv  = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || item_adv;
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  // unpack the stream word; is_mag squared here so the pass stage needs no multiplier
  assign in_mag = in_tdata[mdfm_pkg::MAG_LSB +: mdfm_pkg::MAG_W];
  always_comb begin
    item_nxt.cmd         = in_tuser;
    item_nxt.ia          = in_tdata[mdfm_pkg::IA_LSB +: CurW];
    item_nxt.ib          = in_tdata[mdfm_pkg::IB_LSB +: CurW];
    item_nxt.ic          = in_tdata[mdfm_pkg::IC_LSB +: CurW];
    item_nxt.is_mag      = in_mag;
    item_nxt.is_sq       = SqW'(in_mag) * SqW'(in_mag);
    item_nxt.vdc         = in_tdata[mdfm_pkg::VDC_LSB +: mdfm_pkg::VDC_W];
    item_nxt.temperature = in_tdata[mdfm_pkg::TEMP_LSB +: mdfm_pkg::TEMP_W];
    item_nxt.hw_trip     = in_tdata[mdfm_pkg::HW_LSB];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= '0;
    end else begin
      if (in_acc)
        item_vld_r <= 1'b1;
      else if (item_adv)
        item_vld_r <= 1'b0;

      if (item_adv)
        out_vld_r <= 1'b1;
      else if (out_tready)
        out_vld_r <= 1'b0;

      if (item_adv)
        st_r <= st_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc)
      item_r <= item_nxt;
    if (item_adv)
      out_data_r <= OutW'({oc_evt, st_nxt.fault_latch});
  end

endmodule

### hdl/mdfm_cfg.sv
// Fault monitor configuration registers behind an APB-style port.
// Depends on mdfm_pkg; keeps the squared continuous current ready for the overload sum.
module mdfm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mdfm_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mdfm_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mdfm_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output mdfm_pkg::cfg_t                   cfg
);

  localparam int MagW = mdfm_pkg::MAG_W;
  localparam int SqW  = mdfm_pkg::SQ_W;
  localparam int DatW = mdfm_pkg::APB_DATA_W;

  logic [MagW-1:0]                 ol_cont_r;
  mdfm_pkg::cfg_t                  cfg_r;
  logic                            wr_en;
  logic [2:0]                      reg_idx;
  logic [MagW-1:0]                 wr_cur;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[5:3];
  assign wr_cur  = pwdata[MagW-1:0];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oc_trip        <= mdfm_pkg::OC_TRIP_RST;
      cfg_r.ov_trip        <= mdfm_pkg::OV_TRIP_RST;
      cfg_r.uv_trip        <= mdfm_pkg::UV_TRIP_RST;
      cfg_r.debounce_count <= mdfm_pkg::DEBOUNCE_RST;
      cfg_r.ot_trip        <= mdfm_pkg::OT_TRIP_RST;
      cfg_r.ol_sq          <= mdfm_pkg::OL_SQ_RST;
      cfg_r.sum_trip       <= mdfm_pkg::SUM_TRIP_RST;
      ol_cont_r            <= mdfm_pkg::OL_CONT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        mdfm_pkg::REG_OC_TRIP:  cfg_r.oc_trip        <= pwdata[MagW-1:0];
        mdfm_pkg::REG_OV_TRIP:  cfg_r.ov_trip        <= pwdata[mdfm_pkg::VDC_W-1:0];
        mdfm_pkg::REG_UV_TRIP:  cfg_r.uv_trip        <= pwdata[mdfm_pkg::VDC_W-1:0];
        mdfm_pkg::REG_DEBOUNCE: cfg_r.debounce_count <= pwdata[15:0];
        mdfm_pkg::REG_OT_TRIP:  cfg_r.ot_trip        <= pwdata[mdfm_pkg::TEMP_W-1:0];
        mdfm_pkg::REG_OL_CONT: begin
          ol_cont_r   <= wr_cur;
          cfg_r.ol_sq <= SqW'(wr_cur) * SqW'(wr_cur);
        end
        mdfm_pkg::REG_SUM_TRIP: cfg_r.sum_trip       <= pwdata[mdfm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mdfm_pkg::REG_OC_TRIP:  prdata = DatW'(cfg_r.oc_trip);
      mdfm_pkg::REG_OV_TRIP:  prdata = DatW'(cfg_r.ov_trip);
      mdfm_pkg::REG_UV_TRIP:  prdata = DatW'(cfg_r.uv_trip);
      mdfm_pkg::REG_DEBOUNCE: prdata = DatW'(cfg_r.debounce_count);
      mdfm_pkg::REG_OT_TRIP:  prdata = DatW'(unsigned'(cfg_r.ot_trip));
      mdfm_pkg::REG_OL_CONT:  prdata = DatW'(ol_cont_r);
      mdfm_pkg::REG_SUM_TRIP: prdata = DatW'(cfg_r.sum_trip);
      default:                prdata = '0;
    endcase
  end

endmodule

### hdl/mdfm_eval.sv
// Next-state logic of the fault monitor for one registered item.
// Depends on mdfm_pkg; pure combinational, state is held by the top level.
module mdfm_eval (
  input  mdfm_pkg::item_t  item,
  input  mdfm_pkg::state_t st,
  input  mdfm_pkg::cfg_t   cfg,
  output mdfm_pkg::state_t st_nxt,
  output logic             oc_evt
);

  localparam int AccW  = mdfm_pkg::ACCUM_BITS;
  localparam int AccXW = mdfm_pkg::ACCUM_BITS + 1;
  localparam int CmpW  = mdfm_pkg::CMP_W;
  localparam int SqW   = mdfm_pkg::SQ_W;

  always_comb begin
    logic [SqW-1:0]   diff;
    logic [AccXW-1:0] sum_up;
    logic [AccW-1:0]  sum_new;

    st_nxt  = st;
    oc_evt  = 1'b0;
    diff    = '0;
    sum_up  = '0;
    sum_new = st.ol_sum;

    case (item.cmd)
      mdfm_pkg::CMD_FAST: begin
        if (CmpW'(mdfm_pkg::cur_mag(item.ia)) > CmpW'(cfg.oc_trip))
          st_nxt.fault_latch[mdfm_pkg::FB_OC_A] = 1'b1;
        if (CmpW'(mdfm_pkg::cur_mag(item.ib)) > CmpW'(cfg.oc_trip))
          st_nxt.fault_latch[mdfm_pkg::FB_OC_B] = 1'b1;
        if (CmpW'(mdfm_pkg::cur_mag(item.ic)) > CmpW'(cfg.oc_trip))
          st_nxt.fault_latch[mdfm_pkg::FB_OC_C] = 1'b1;
        if (item.is_mag > cfg.oc_trip) begin
          st_nxt.fault_latch[mdfm_pkg::FB_OC_MAG] = 1'b1;
          oc_evt = 1'b1;
        end
        st_nxt.ov_cnt = mdfm_pkg::debounce(st.ov_cnt, item.vdc > cfg.ov_trip);
        if (CmpW'(st_nxt.ov_cnt) >= CmpW'(cfg.debounce_count))
          st_nxt.fault_latch[mdfm_pkg::FB_OV] = 1'b1;
        st_nxt.uv_cnt = mdfm_pkg::debounce(st.uv_cnt, item.vdc < cfg.uv_trip);
        if (CmpW'(st_nxt.uv_cnt) >= CmpW'(cfg.debounce_count))
          st_nxt.fault_latch[mdfm_pkg::FB_UV] = 1'b1;
        if (item.hw_trip)
          st_nxt.fault_latch[mdfm_pkg::FB_HW] = 1'b1;
      end
      mdfm_pkg::CMD_SLOW: begin
        // I^2t: add the excess over the continuous level or subtract the shortfall, floor at zero, saturate at the top
        if (item.is_sq >= cfg.ol_sq) begin
          diff    = item.is_sq - cfg.ol_sq;
          sum_up  = {1'b0, st.ol_sum} + AccXW'(diff);
          sum_new = sum_up[AccW] ? '1 : sum_up[AccW-1:0];
        end else begin
          diff    = cfg.ol_sq - item.is_sq;
          sum_new = (AccW'(diff) >= st.ol_sum) ? '0 : st.ol_sum - AccW'(diff);
        end
        if (64'(sum_new) > 64'(cfg.sum_trip)) begin
          st_nxt.fault_latch[mdfm_pkg::FB_OL] = 1'b1;
          st_nxt.ol_sum = '0;
        end else begin
          st_nxt.ol_sum = sum_new;
        end
        st_nxt.ot_cnt = mdfm_pkg::debounce(st.ot_cnt,
                                           $signed(item.temperature) > $signed(cfg.ot_trip));
        if (CmpW'(st_nxt.ot_cnt) >= CmpW'(cfg.debounce_count))
          st_nxt.fault_latch[mdfm_pkg::FB_OT] = 1'b1;
      end
      mdfm_pkg::CMD_CLEAR: begin
        st_nxt = '0;
      end
      default: ;  // unused command: state unchanged
    endcase
  end

endmodule

### hdl/mdfm_checker.sv
// Port-level checks for the fault monitor, bound to the top level.
// Depends on mdfm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mdfm_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mdfm_pkg::OUT_DATA_W-1:0]   out_tdata
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] infl_r;
  logic [1:0] infl_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // items accepted but not yet delivered
  always_comb begin
    infl_nxt = infl_r;
    if (in_acc && !out_acc)
      infl_nxt = infl_r + 2'd1;
    else if (!in_acc && out_acc)
      infl_nxt = infl_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      infl_r <= 2'd0;
    end else begin
      infl_r <= infl_nxt;
    end
  end

  `CHK_ASSERT(a_infl_max, infl_r != 2'd3, "more than two items held in the block")
  `CHK_ASSERT(a_no_phantom, out_tvalid |-> infl_r != 2'd0, "result without an accepted item")
  `CHK_ASSERT(a_evt_flag, out_tvalid && out_tdata[mdfm_pkg::OUT_EVT_BIT] |-> out_tdata[mdfm_pkg::FB_OC_MAG], "event without latched magnitude flag")
  `CHK_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")
  `CHK_ASSERT_NR(a_rst_empty, $past(!rst_n) |-> !out_tvalid, "result valid right after reset")

endmodule

bind motor_drive_fault_monitor_top mdfm_checker u_mdfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
